@@ hw/rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 13;
    localparam int COUNT_W  = 14;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic has_zero;
        logic sel_bit;
    } t_word_flags;

endpackage

@@ hw/rtl/bba_bitmap_ram.sv @@
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Bitmap word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/bba_word_unit.sv @@
// ----------------------------------------------------------------------------
// bba_word_unit
// Shared bitmap word unit: lowest zero bit search, bit read and bit update.
// ----------------------------------------------------------------------------
module bba_word_unit
    import bba_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int BW        = 6
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [BW-1:0]        i_sel,
    input  logic                 i_set,
    output logic [BW-1:0]        o_first_zero,
    output t_word_flags          o_flags,
    output logic [WORD_BITS-1:0] o_word
);

    always_comb begin
        o_first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_first_zero = BW'(i);
            end
        end
    end

    always_comb begin
        o_word         = i_word;
        o_word[i_sel]  = i_set;
        o_flags.has_zero = ~&i_word;
        o_flags.sel_bit  = i_word[i_sel];
    end

endmodule

@@ hw/rtl/bitmap_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit disk block allocator over a used-block bitmap with a used count.
// ----------------------------------------------------------------------------
// The bitmap sits in a single-port-read memory of NUM_WORDS words. After reset
// the block clears the memory, one word per cycle, and holds o_in_stall high
// meanwhile. One item is in work at a time. Allocate scans words through the
// memory read port, one word per cycle; free, mark and query go through accept,
// block number split, word read and update. A finished result waits in the
// output register while the next item is taken in.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 8192,
    parameter int WORD_BITS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BLOCK_W-1:0]  i_block_number,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic [BLOCK_W-1:0]  o_result_block,
    output logic                o_was_used,
    output logic [COUNT_W-1:0]  o_used_count
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int SHIFT     = BLOCK_W + $clog2(WORD_BITS);
    localparam int RECIP     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_REM   = 3'd3;
    localparam logic [2:0] S_POINT = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_ALLOC = 3'd6;
    localparam logic [2:0] S_FULL  = 3'd7;

    logic [2:0]           r_state;
    logic [ACTION_W-1:0]  r_act;
    logic [BLOCK_W-1:0]   r_blk;
    logic [BLOCK_W-1:0]   r_q;
    logic [BW-1:0]        r_bit;
    logic                 r_inrange;
    logic [AW:0]          r_addr;
    logic                 r_pend;
    logic [AW-1:0]        r_pend_addr;
    logic [WORD_BITS-1:0] r_word;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_status;
    logic [BLOCK_W-1:0]   r_result;
    logic                 r_was_used;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [WORD_BITS-1:0] unit_word;
    logic                 unit_set;
    logic [BW-1:0]        first_zero;
    t_word_flags          flags;
    logic [WORD_BITS-1:0] new_word;

    logic                 out_free;
    logic                 old_bit;
    logic                 do_free;
    logic                 do_mark;
    logic [31:0]          prod;
    logic [31:0]          quot;
    logic [31:0]          qd;
    logic [31:0]          rem;
    logic [31:0]          alloc_blk;
    logic                 alloc_ok;
    logic [31:0]          cnt_ext;

    bba_bitmap_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bba_word_unit #(
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
    ) u_word (
        .i_word       (unit_word),
        .i_sel        (r_bit),
        .i_set        (unit_set),
        .o_first_zero (first_zero),
        .o_flags      (flags),
        .o_word       (new_word)
    );

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        unit_word = ((r_state == S_POINT) || (r_state == S_SCAN)) ? rd_data : r_word;
        unit_set  = (r_state == S_POINT) ? (r_act == ACT_MARK) : 1'b1;
        old_bit   = r_inrange && flags.sel_bit;
        do_free   = (r_act == ACT_FREE) && old_bit;
        do_mark   = (r_act == ACT_MARK) && !old_bit && r_inrange;

        prod      = 32'(r_blk) * 32'(RECIP);
        quot      = prod >> SHIFT;
        qd        = 32'(r_q) * 32'(WORD_BITS);
        rem       = 32'(r_blk) - qd;
        alloc_blk = qd + 32'(r_bit);
        alloc_ok  = alloc_blk < 32'(NUM_BLOCKS);
        cnt_ext   = 32'(r_count);

        n_out_valid = r_out_valid && i_out_stall;
        if (out_free && ((r_state == S_POINT) || (r_state == S_ALLOC)
                || (r_state == S_FULL))) begin
            n_out_valid = 1'b1;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_q[AW-1:0];
        wr_data = new_word;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr[AW-1:0];
                wr_data = '0;
            end
            S_REM: begin
                rd_en   = r_inrange;
                rd_addr = r_q[AW-1:0];
            end
            S_SCAN: begin
                rd_en = 32'(r_addr) < 32'(NUM_WORDS);
            end
            S_POINT: begin
                wr_en = out_free && (do_free || do_mark);
            end
            S_ALLOC: begin
                wr_en = out_free && alloc_ok;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (32'(r_addr) == 32'(NUM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act  <= i_action;
                        r_blk  <= i_block_number;
                        r_addr <= '0;
                        r_pend <= 1'b0;
                        r_state <= (i_action == ACT_ALLOC) ? S_SCAN : S_DIV;
                    end
                end
                S_DIV: begin
                    r_q       <= quot[BLOCK_W-1:0];
                    r_inrange <= 32'(r_blk) < 32'(NUM_BLOCKS);
                    r_state   <= S_REM;
                end
                S_REM: begin
                    r_bit   <= rem[BW-1:0];
                    r_state <= S_POINT;
                end
                S_POINT: begin
                    if (out_free) begin
                        r_status    <= STATUS_DONE;
                        r_result    <= r_blk;
                        r_was_used  <= old_bit;
                        if (do_free) begin
                            r_count <= r_count - CNT_W'(1);
                        end else if (do_mark) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_pend      <= rd_en;
                    r_pend_addr <= r_addr[AW-1:0];
                    if (r_pend) begin
                        if (flags.has_zero) begin
                            r_word  <= rd_data;
                            r_bit   <= first_zero;
                            r_q     <= BLOCK_W'(r_pend_addr);
                            r_state <= S_ALLOC;
                        end else if (32'(r_pend_addr) == 32'(NUM_WORDS - 1)) begin
                            r_state <= S_FULL;
                        end
                    end
                end
                S_ALLOC: begin
                    if (out_free) begin
                        r_was_used  <= 1'b0;
                        if (alloc_ok) begin
                            r_status <= STATUS_DONE;
                            r_result <= alloc_blk[BLOCK_W-1:0];
                            r_count  <= r_count + CNT_W'(1);
                        end else begin
                            r_status <= STATUS_FULL;
                            r_result <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FULL: begin
                    if (out_free) begin
                        r_status    <= STATUS_FULL;
                        r_result    <= '0;
                        r_was_used  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_block = r_result;
    assign o_was_used     = r_was_used;
    assign o_used_count   = cnt_ext[COUNT_W-1:0];

endmodule

@@ hw/rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [ACTION_W-1:0] i_action,
    input logic [BLOCK_W-1:0]  i_block_number,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_status,
    input logic [BLOCK_W-1:0]  o_result_block,
    input logic                o_was_used,
    input logic [COUNT_W-1:0]  o_used_count
);

    a_reset_drops_result: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_out_valid
    ) else $error("result valid right after reset");

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall
    ) else $error("input taken again before the item finished");

    a_full_result_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_FULL) |-> (o_result_block == '0) && !o_was_used
    ) else $error("disk-full result carries a block or a used flag");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_result_block) && $stable(o_was_used) && $stable(o_used_count)
    ) else $error("stalled result changed");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);
